// ===== rtl/core/btop_pkg.sv =====
// ----------------------------------------------------------------------------
// Box table package
// Shared types, codes and constants for the box table overlap and push-out
// block.
// ----------------------------------------------------------------------------
package btop_pkg;

    localparam int MAX_BOXES_DEF = 256;
    localparam int COORD_W       = 16;
    localparam int VIEW_W        = 15;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int HIT_IDX_W     = 8;

    localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = 15'd320;
    localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = 15'd224;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [1:0]         t_dir;

    typedef enum logic [2:0] {
        KIND_REG   = 3'd0,
        KIND_CLEAR = 3'd1,
        KIND_CULL  = 3'd2,
        KIND_VIEW  = 3'd3,
        KIND_QUERY = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_WIDTH  = 8'd0,
        CFG_VIEW_HEIGHT = 8'd1
    } t_cfg_idx;

    typedef struct packed {
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_box;

    typedef struct packed {
        logic pos_x;
        logic neg_x;
        logic pos_y;
        logic neg_y;
    } t_push_ctl;

endpackage

// ===== rtl/core/btop_if.sv =====
// ----------------------------------------------------------------------------
// Box table channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface btop_in_if;
    import btop_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] kind;
    t_coord     box_min_x;
    t_coord     box_min_y;
    t_coord     box_max_x;
    t_coord     box_max_y;
    t_coord     pos_x;
    t_coord     pos_y;
    t_dir       dir_x;
    t_dir       dir_y;
    logic       culling_on;

    modport source (
        output valid, kind, box_min_x, box_min_y, box_max_x, box_max_y,
               pos_x, pos_y, dir_x, dir_y, culling_on,
        input  ready
    );
    modport sink (
        input  valid, kind, box_min_x, box_min_y, box_max_x, box_max_y,
               pos_x, pos_y, dir_x, dir_y, culling_on,
        output ready
    );
endinterface

interface btop_out_if;
    import btop_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [HIT_IDX_W-1:0] hit_index;
    t_coord               new_pos_x;
    t_coord               new_pos_y;
    logic                 dropped;

    modport source (
        output valid, hit, hit_index, new_pos_x, new_pos_y, dropped,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_index, new_pos_x, new_pos_y, dropped,
        output ready
    );
endinterface

interface btop_cfg_if;
    import btop_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/box_table_overlap_pushout.sv =====
// ----------------------------------------------------------------------------
// Box table overlap and push-out
// Table of boxes with active flags, scanned one entry per cycle through the
// box memory read port by a shared overlap unit.
// ----------------------------------------------------------------------------
// Register, clear and unused kinds go from accept straight to the result state.
// Set culling makes one flag write per stored box (N boxes).
// View update and query read one stored box per cycle from the registered box
// memory read port; a query stops early at its first hit.
// One item is in work at a time; a new one is taken once the result is queued.
// Reset clears control state; the box and flag memories are not cleared.
module box_table_overlap_pushout #(
    parameter int MAX_BOXES = btop_pkg::MAX_BOXES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btop_in_if.sink     i_in,
    btop_out_if.source  o_out,
    btop_cfg_if.sink    i_cfg
);
    import btop_pkg::*;

    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SWEEP, S_RESP} t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_cull, n_cull;
    logic                 r_con, n_con;
    t_coord               r_last_x, n_last_x;
    t_coord               r_last_y, n_last_y;
    logic [VIEW_W-1:0]    r_view_w, n_view_w;
    logic [VIEW_W-1:0]    r_view_h, n_view_h;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pv, n_pv;
    logic [IW-1:0]        r_tidx, n_tidx;
    logic                 r_is_query, n_is_query;
    t_box                 r_ref, n_ref;
    t_coord               r_pos_x, n_pos_x;
    t_coord               r_pos_y, n_pos_y;
    t_push_ctl            r_ctl, n_ctl;
    logic                 r_res_hit, n_res_hit;
    logic [HIT_IDX_W-1:0] r_res_idx, n_res_idx;
    t_coord               r_res_x, n_res_x;
    t_coord               r_res_y, n_res_y;
    logic                 r_res_drop, n_res_drop;
    logic                 r_ov, n_ov;
    logic                 r_o_hit, n_o_hit;
    logic [HIT_IDX_W-1:0] r_o_idx, n_o_idx;
    t_coord               r_o_x, n_o_x;
    t_coord               r_o_y, n_o_y;
    logic                 r_o_drop, n_o_drop;

    t_box                 r_box_mem [MAX_BOXES];
    logic                 r_flag_mem [MAX_BOXES];
    t_box                 r_rd_box;
    logic                 r_rd_flag;

    logic                 box_we;
    logic                 flag_we;
    logic [IW-1:0]        flag_waddr;
    logic                 flag_wdata;
    logic [IW-1:0]        rd_addr;
    logic                 in_acc;
    logic                 issue;
    logic                 ovl;
    t_coord               push_x;
    t_coord               push_y;
    t_box                 in_box;
    logic [IW+HIT_IDX_W-1:0] tidx_ext;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign in_box      = '{x0: i_in.box_min_x, y0: i_in.box_min_y,
                           x1: i_in.box_max_x, y1: i_in.box_max_y};
    assign rd_addr     = r_idx[IW-1:0];
    assign issue       = (r_idx < r_count);
    assign tidx_ext    = {{HIT_IDX_W{1'b0}}, r_tidx};

    assign o_out.valid     = r_ov;
    assign o_out.hit       = r_o_hit;
    assign o_out.hit_index = r_o_idx;
    assign o_out.new_pos_x = r_o_x;
    assign o_out.new_pos_y = r_o_y;
    assign o_out.dropped   = r_o_drop;

    btop_ovl u_ovl (
        .i_box (r_rd_box),
        .i_ref (r_ref),
        .o_ovl (ovl)
    );

    btop_push u_push (
        .i_hit   (r_rd_box),
        .i_qry   (r_ref),
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .i_ctl   (r_ctl),
        .o_new_x (push_x),
        .o_new_y (push_y)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cull     = r_cull;
        n_con      = r_con;
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_view_w   = r_view_w;
        n_view_h   = r_view_h;
        n_idx      = r_idx;
        n_pv       = r_pv;
        n_tidx     = r_tidx;
        n_is_query = r_is_query;
        n_ref      = r_ref;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_ctl      = r_ctl;
        n_res_hit  = r_res_hit;
        n_res_idx  = r_res_idx;
        n_res_x    = r_res_x;
        n_res_y    = r_res_y;
        n_res_drop = r_res_drop;
        n_ov       = r_ov;
        n_o_hit    = r_o_hit;
        n_o_idx    = r_o_idx;
        n_o_x      = r_o_x;
        n_o_y      = r_o_y;
        n_o_drop   = r_o_drop;
        box_we     = 1'b0;
        flag_we    = 1'b0;
        flag_waddr = r_count[IW-1:0];
        flag_wdata = !r_cull;

        if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_VIEW_WIDTH:  n_view_w = i_cfg.data[VIEW_W-1:0];
                CFG_VIEW_HEIGHT: n_view_h = i_cfg.data[VIEW_W-1:0];
                default: ;
            endcase
        end

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ref      = in_box;
                    n_pos_x    = i_in.pos_x;
                    n_pos_y    = i_in.pos_y;
                    n_ctl      = '{pos_x: (i_in.dir_x == 2'sb01), neg_x: i_in.dir_x[1],
                                   pos_y: (i_in.dir_y == 2'sb01), neg_y: i_in.dir_y[1]};
                    n_res_hit  = 1'b0;
                    n_res_idx  = '0;
                    n_res_x    = '0;
                    n_res_y    = '0;
                    n_res_drop = 1'b0;
                    n_idx      = '0;
                    n_pv       = 1'b0;
                    n_is_query = 1'b0;
                    n_state    = S_RESP;
                    case (t_kind'(i_in.kind))
                        KIND_REG: begin
                            if (r_count >= CW'(MAX_BOXES)) begin
                                n_res_drop = 1'b1;
                            end else begin
                                box_we  = 1'b1;
                                flag_we = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        KIND_CULL: begin
                            n_cull  = i_in.culling_on;
                            n_con   = i_in.culling_on;
                            n_state = S_SWEEP;
                        end
                        KIND_VIEW: begin
                            if (r_cull && (i_in.box_min_x != r_last_x ||
                                           i_in.box_min_y != r_last_y)) begin
                                n_last_x = i_in.box_min_x;
                                n_last_y = i_in.box_min_y;
                                n_ref.x1 = t_coord'(i_in.box_min_x +
                                                    $signed({1'b0, r_view_w}));
                                n_ref.y1 = t_coord'(i_in.box_min_y +
                                                    $signed({1'b0, r_view_h}));
                                n_state  = S_SCAN;
                            end
                        end
                        KIND_QUERY: begin
                            n_is_query = 1'b1;
                            n_res_x    = i_in.pos_x;
                            n_res_y    = i_in.pos_y;
                            n_state    = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                if (issue) begin
                    flag_we    = 1'b1;
                    flag_waddr = r_idx[IW-1:0];
                    flag_wdata = !r_con;
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                n_pv   = issue;
                n_tidx = r_idx[IW-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pv) begin
                    if (r_is_query) begin
                        if (r_rd_flag && ovl) begin
                            n_res_hit = 1'b1;
                            n_res_idx = tidx_ext[HIT_IDX_W-1:0];
                            n_res_x   = push_x;
                            n_res_y   = push_y;
                            n_pv      = 1'b0;
                            n_state   = S_RESP;
                        end
                    end else begin
                        flag_we    = 1'b1;
                        flag_waddr = r_tidx;
                        flag_wdata = ovl;
                    end
                end else if (!issue) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_ov || o_out.ready) begin
                    n_ov     = 1'b1;
                    n_o_hit  = r_res_hit;
                    n_o_idx  = r_res_idx;
                    n_o_x    = r_res_x;
                    n_o_y    = r_res_y;
                    n_o_drop = r_res_drop;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cull   <= 1'b0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_view_w <= VIEW_WIDTH_RST;
            r_view_h <= VIEW_HEIGHT_RST;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cull   <= n_cull;
            r_last_x <= n_last_x;
            r_last_y <= n_last_y;
            r_view_w <= n_view_w;
            r_view_h <= n_view_h;
            r_idx    <= n_idx;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
        r_con      <= n_con;
        r_tidx     <= n_tidx;
        r_is_query <= n_is_query;
        r_ref      <= n_ref;
        r_pos_x    <= n_pos_x;
        r_pos_y    <= n_pos_y;
        r_ctl      <= n_ctl;
        r_res_hit  <= n_res_hit;
        r_res_idx  <= n_res_idx;
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
        r_res_drop <= n_res_drop;
        r_o_hit    <= n_o_hit;
        r_o_idx    <= n_o_idx;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_drop   <= n_o_drop;
    end

    always_ff @(posedge i_clk) begin
        if (box_we) begin
            r_box_mem[r_count[IW-1:0]] <= in_box;
        end
        r_rd_box <= r_box_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_flag_mem[flag_waddr] <= flag_wdata;
        end
        r_rd_flag <= r_flag_mem[rd_addr];
    end

endmodule

// ===== rtl/core/btop_ovl.sv =====
// ----------------------------------------------------------------------------
// Box table overlap unit
// Strict overlap test of a stored box against the reference box, shared by
// the view update and the query scans.
// ----------------------------------------------------------------------------
module btop_ovl (
    input  btop_pkg::t_box i_box,
    input  btop_pkg::t_box i_ref,
    output logic           o_ovl
);

    assign o_ovl = (i_box.x0 < i_ref.x1) && (i_box.x1 > i_ref.x0) &&
                   (i_box.y0 < i_ref.y1) && (i_box.y1 > i_ref.y0);

endmodule

// ===== rtl/core/btop_push.sv =====
// ----------------------------------------------------------------------------
// Box table push-out unit
// Moves the querying position out of the hit box along the sign of each
// direction component, wrapping at the coordinate width.
// ----------------------------------------------------------------------------
module btop_push (
    input  btop_pkg::t_box      i_hit,
    input  btop_pkg::t_box      i_qry,
    input  btop_pkg::t_coord    i_pos_x,
    input  btop_pkg::t_coord    i_pos_y,
    input  btop_pkg::t_push_ctl i_ctl,
    output btop_pkg::t_coord    o_new_x,
    output btop_pkg::t_coord    o_new_y
);

    always_comb begin
        o_new_x = i_pos_x;
        if (i_ctl.pos_x) begin
            o_new_x = i_pos_x - (i_qry.x1 - i_hit.x0);
        end else if (i_ctl.neg_x) begin
            o_new_x = i_pos_x + (i_hit.x1 - i_qry.x0);
        end
        o_new_y = i_pos_y;
        if (i_ctl.pos_y) begin
            o_new_y = i_pos_y - (i_qry.y1 - i_hit.y0);
        end else if (i_ctl.neg_y) begin
            o_new_y = i_pos_y + (i_hit.y1 - i_qry.y0);
        end
    end

endmodule

// ===== rtl/core/btop_chk.sv =====
// ----------------------------------------------------------------------------
// Box table port checker
// Checks the result channel and the item handshake seen on the top level's
// ports.
// ----------------------------------------------------------------------------
module btop_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic                            i_out_hit,
    input logic [btop_pkg::HIT_IDX_W-1:0]  i_out_hit_index,
    input btop_pkg::t_coord                i_out_new_pos_x,
    input btop_pkg::t_coord                i_out_new_pos_y,
    input logic                            i_out_dropped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_out_hit, i_out_hit_index, i_out_new_pos_x,
                     i_out_new_pos_y, i_out_dropped}))
        else $error("Result item changed while stalled.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Item accepted while the previous one is still in work.");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> i_out_hit_index == '0)
        else $error("Hit index set without a hit.");

    a_hit_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_hit && i_out_dropped))
        else $error("Result shows both a hit and a dropped box.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid straight after reset.");

endmodule

bind box_table_overlap_pushout btop_chk u_btop_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_hit       (o_out.hit),
    .i_out_hit_index (o_out.hit_index),
    .i_out_new_pos_x (o_out.new_pos_x),
    .i_out_new_pos_y (o_out.new_pos_y),
    .i_out_dropped   (o_out.dropped)
);
